/* rtl/core/smf_pkg.sv */
`timescale 1ns / 1ps
// smf_pkg: shared types for the sequence mode finder
// controller states and the command / status structs between controller and datapath

package smf_pkg;

    // width of the sequence mark kept with each count entry; mark 0 means never written
    localparam int EPOCH_BITS = 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_ACCEPT,
        ST_UPDATE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_END
    } smf_state_t;

    typedef struct packed {
        logic accept;     // latch item, read its count entry
        logic update;     // count the latched label
        logic clr_write;  // clearing pass write
        logic emit_read;  // read tie list entry
        logic emit_load;  // load result register
        logic end_seq;    // drop sequence state
    } smf_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic item_last;
        logic emit_last;
        logic out_free;
        logic epoch_wrap;
    } smf_status_t;

endpackage

/* rtl/core/smf_ctrl.sv */
`timescale 1ns / 1ps
// smf_ctrl: controller state machine of the sequence mode finder
// depends on smf_pkg

module smf_ctrl import smf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  smf_status_t status,
    output smf_cmd_t    cmd
);

    smf_state_t state_reg;
    smf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_ACCEPT: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.item_last ? ST_EMIT_RD : ST_ACCEPT;
            end
            ST_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_last ? ST_END : ST_EMIT_RD;
                end
            end
            ST_END: begin
                cmd.end_seq = 1'b1;
                // marks ran out: old entries could match again, so wipe the store
                state_next  = status.epoch_wrap ? ST_CLEAR : ST_ACCEPT;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/smf_datapath.sv */
`timescale 1ns / 1ps
// smf_datapath: count store, best count, tie list and result register
// depends on smf_pkg, driven by smf_ctrl

module smf_datapath import smf_pkg::*; #(
    parameter int LABEL_BITS = 10,
    parameter int MAX_ITEMS  = 4096,
    parameter int TIE_DEPTH  = 64,
    parameter int CNT_BITS   = $clog2(MAX_ITEMS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smf_cmd_t              cmd,
    output smf_status_t           status,
    input  logic [LABEL_BITS-1:0] s_label,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LABEL_BITS-1:0] m_label,
    output logic [CNT_BITS-1:0]   m_count,
    output logic                  m_trunc,
    output logic                  m_last
);

    localparam int LABEL_SPACE = 1 << LABEL_BITS;
    localparam int WORD_BITS   = EPOCH_BITS + CNT_BITS;
    localparam int IDX_BITS    = $clog2(TIE_DEPTH);
    localparam int TL_BITS     = $clog2(TIE_DEPTH + 1);
    localparam int TLX_BITS    = TL_BITS + 1;

    // count store: {sequence mark, count}
    logic [WORD_BITS-1:0]  cnt_mem [LABEL_SPACE];
    logic [WORD_BITS-1:0]  cnt_rd_reg;
    logic [LABEL_BITS-1:0] tie_mem [TIE_DEPTH];
    logic [LABEL_BITS-1:0] tie_rd_reg;

    logic [LABEL_BITS-1:0] label_reg;
    logic                  last_reg;
    logic [LABEL_BITS-1:0] clr_addr_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [CNT_BITS-1:0]   best_reg;
    logic [TL_BITS-1:0]    tie_len_reg;
    logic                  ovf_reg;
    logic [IDX_BITS-1:0]   emit_idx_reg;
    logic                  m_valid_reg;
    logic [LABEL_BITS-1:0] m_label_reg;
    logic [CNT_BITS-1:0]   m_count_reg;
    logic                  m_trunc_reg;
    logic                  m_last_reg;

    logic                  seen;
    logic                  saturated;
    logic [CNT_BITS-1:0]   new_cnt;
    logic                  cnt_we;
    logic [LABEL_BITS-1:0] cnt_wa;
    logic [WORD_BITS-1:0]  cnt_wd;
    logic                  new_best;
    logic                  tie_hit;
    logic                  tie_room;
    logic                  tie_we;
    logic [IDX_BITS-1:0]   tie_wa;
    logic                  emit_last;

    assign seen      = cnt_rd_reg[WORD_BITS-1 -: EPOCH_BITS] == epoch_reg;
    assign saturated = seen && (cnt_rd_reg[CNT_BITS-1:0] >= CNT_BITS'(MAX_ITEMS));
    assign new_cnt   = seen ? cnt_rd_reg[CNT_BITS-1:0] + CNT_BITS'(1) : CNT_BITS'(1);
    assign new_best  = !saturated && (new_cnt > best_reg);
    assign tie_hit   = !saturated && (new_cnt == best_reg);
    assign tie_room  = tie_len_reg < TL_BITS'(TIE_DEPTH);

    assign cnt_we = cmd.clr_write || (cmd.update && !saturated);
    assign cnt_wa = cmd.clr_write ? clr_addr_reg : label_reg;
    assign cnt_wd = cmd.clr_write ? '0 : {epoch_reg, new_cnt};

    assign tie_we = cmd.update && (new_best || (tie_hit && tie_room));
    assign tie_wa = new_best ? '0 : tie_len_reg[IDX_BITS-1:0];

    assign emit_last = (TLX_BITS'(emit_idx_reg) + TLX_BITS'(1)) == TLX_BITS'(tie_len_reg);

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.accept) begin
            cnt_rd_reg <= cnt_mem[s_label];
        end
    end

    always_ff @(posedge aclk) begin
        if (tie_we) begin
            tie_mem[tie_wa] <= label_reg;
        end
        if (cmd.emit_read) begin
            tie_rd_reg <= tie_mem[emit_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            label_reg <= s_label;
            last_reg  <= s_last;
        end
        if (cmd.emit_load) begin
            m_label_reg <= tie_rd_reg;
            m_count_reg <= best_reg;
            m_trunc_reg <= ovf_reg;
            m_last_reg  <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            epoch_reg    <= EPOCH_BITS'(1);
            best_reg     <= '0;
            tie_len_reg  <= '0;
            ovf_reg      <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_write) begin
                clr_addr_reg <= clr_addr_reg + LABEL_BITS'(1);
            end
            if (cmd.end_seq) begin
                epoch_reg   <= (&epoch_reg) ? EPOCH_BITS'(1) : epoch_reg + EPOCH_BITS'(1);
                best_reg    <= '0;
                tie_len_reg <= '0;
                ovf_reg     <= 1'b0;
            end else if (cmd.update) begin
                if (new_best) begin
                    best_reg    <= new_cnt;
                    tie_len_reg <= TL_BITS'(1);
                    ovf_reg     <= 1'b0;
                end else if (tie_hit) begin
                    if (tie_room) begin
                        tie_len_reg <= tie_len_reg + TL_BITS'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            if (cmd.emit_load) begin
                emit_idx_reg <= emit_last ? '0 : emit_idx_reg + IDX_BITS'(1);
            end
            if (cmd.emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status            = '0;
        status.clr_done   = &clr_addr_reg;
        status.item_last  = last_reg;
        status.emit_last  = emit_last;
        status.out_free   = !m_valid_reg || m_ready;
        status.epoch_wrap = &epoch_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_label = m_label_reg;
    assign m_count = m_count_reg;
    assign m_trunc = m_trunc_reg;
    assign m_last  = m_last_reg;

endmodule

/* rtl/core/sequence_mode_finder_core.sv */
`timescale 1ns / 1ps
// channel  dir  tdata (low bit up)              tuser       tlast
// s_axis   in   label                           -           last item of the sequence
// m_axis   out  mode_label, mode_count          truncated   last mode result
//
// each item is read from its count entry, then counted; no new item is taken meanwhile
// at the end of a sequence each mode result is made by a tie list read and a result load,
// and after the last result the sequence state is dropped
// after reset, and after every 255 sequences, a clearing pass writes all 2**LABEL_BITS
// count store entries while no item is accepted
// a stalled result holds in the output register; the block waits for it before the next one
// top level: sequence_mode_finder_core, uses smf_pkg, smf_ctrl and smf_datapath

module sequence_mode_finder_core import smf_pkg::*; #(
    parameter int LABEL_BITS = 10,
    parameter int MAX_ITEMS  = 4096,
    parameter int TIE_DEPTH  = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((LABEL_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // label
    input  logic                                    s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // mode_label, mode_count
    output logic [((LABEL_BITS + $clog2(MAX_ITEMS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                    m_axis_tuser,  // truncated
    output logic                                    m_axis_tlast
);

    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int M_TDATA_W = ((LABEL_BITS + CNT_BITS + 7) / 8) * 8;

    smf_cmd_t              cmd;
    smf_status_t           status;
    logic [LABEL_BITS-1:0] m_label;
    logic [CNT_BITS-1:0]   m_count;

    smf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    smf_datapath #(
        .LABEL_BITS (LABEL_BITS),
        .MAX_ITEMS  (MAX_ITEMS),
        .TIE_DEPTH  (TIE_DEPTH),
        .CNT_BITS   (CNT_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_label (s_axis_tdata[LABEL_BITS-1:0]),
        .s_last  (s_axis_tlast),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_label (m_label),
        .m_count (m_count),
        .m_trunc (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = M_TDATA_W'({m_count, m_label});

endmodule

/* rtl/core/smf_checker.sv */
`timescale 1ns / 1ps
// smf_checker: port level checks of sequence_mode_finder_core
// bound to the top level below

module smf_checker #(
    parameter int LABEL_BITS = 10,
    parameter int MAX_ITEMS  = 4096
) (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((LABEL_BITS + $clog2(MAX_ITEMS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

    // a waiting result keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every mode has been seen at least once
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[LABEL_BITS +: CNT_BITS] != '0)
        else $error("mode count is zero");

    // an accepted item is counted before the next one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted during count update");

    // reset leaves the block clearing with no result pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !s_axis_tready)
        else $error("block active right after reset");

endmodule

bind sequence_mode_finder_core smf_checker #(
    .LABEL_BITS (LABEL_BITS),
    .MAX_ITEMS  (MAX_ITEMS)
) u_smf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
